// ===== sv/rsa_modexp_engine_macros.svh =====
// Assertion helpers for the modular exponentiation engine.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef RSA_MODEXP_ENGINE_MACROS_SVH
`define RSA_MODEXP_ENGINE_MACROS_SVH

// Same-cycle implication.
`define RME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rme_pkg.sv =====
`timescale 1ns / 1ps

package rme_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = $clog2(DATA_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd2;

  // Request function codes
  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  // Start command for the modular multiplier
  typedef struct packed {
    logic start;
    logic reduce;  // plain reduction of the a operand, b is ignored
  } mm_ctrl_t;

endpackage

// ===== sv/rme_if.sv =====
`timescale 1ns / 1ps

// Request channel: one operand and the function select
interface rme_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [rme_pkg::DATA_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

// Response channel: one result per request
interface rme_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [rme_pkg::DATA_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// Configuration write channel
interface rme_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rme_pkg::CFG_IDX_W-1:0] index;
  logic [rme_pkg::DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/rme_mulmod.sv =====
`timescale 1ns / 1ps

// Bit-serial interleaved modular multiplier, multiplier bits MSB first.
// Each bit takes a double-and-reduce step, then an add-and-reduce step.
module rme_mulmod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rme_pkg::mm_ctrl_t          ctrl_i,
  input  logic [rme_pkg::DATA_W-1:0] a_i,
  input  logic [rme_pkg::DATA_W-1:0] b_i,
  input  logic [rme_pkg::DATA_W-1:0] m_i,
  input  logic                       m_zero_i,
  output logic                       done_o,
  output logic [rme_pkg::DATA_W-1:0] r_o
);

  localparam int W = rme_pkg::DATA_W;
  localparam logic [rme_pkg::CNT_W-1:0] CNT_LAST = rme_pkg::CNT_W'(W - 1);

  logic [W-1:0]               a_q, b_q, r_q, r_d;
  logic [rme_pkg::CNT_W-1:0]  cnt_q;
  logic                       busy_q, phase_q, red_q, done_q;
  logic [W:0]                 t;
  logic                       a_bit;

  always_comb begin
    a_bit = a_q[W-1];
    if (!phase_q) begin
      t = {r_q, 1'b0} + (W+1)'(red_q & a_bit);
    end else begin
      t = {1'b0, r_q} + ((!red_q && a_bit) ? {1'b0, b_q} : '0);
    end
    // r < m keeps t below 2m, so one subtract is enough
    if (m_zero_i) begin
      r_d = t[W-1:0];
    end else if (t >= {1'b0, m_i}) begin
      r_d = W'(t - {1'b0, m_i});
    end else begin
      r_d = t[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q     <= '0;
      b_q     <= '0;
      r_q     <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      red_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        a_q     <= a_i;
        b_q     <= b_i;
        r_q     <= '0;
        cnt_q   <= '0;
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        red_q   <= ctrl_i.reduce;
      end else if (busy_q) begin
        r_q     <= r_d;
        phase_q <= ~phase_q;
        if (phase_q) begin
          a_q   <= {a_q[W-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

// ===== sv/rsa_modexp_engine.sv =====
// Modular exponentiation value^e mod n, right-to-left square-and-multiply.
// The value is first reduced modulo n, then one multiply pass runs per exponent bit
// up to the highest set bit; a zero exponent skips both and returns 1.
// Throughput: one request at a time; the serial multiply sets the pace.
// Reset: async active low; modulus and both exponents reset to 1, engine idle.
`timescale 1ns / 1ps

module rsa_modexp_engine #(
  parameter int MOD_WIDTH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rme_req_if.sink   req_i,
  rme_rsp_if.source rsp_o,
  rme_cfg_if.sink   cfg_i
);

  localparam int W  = rme_pkg::DATA_W;
  // Only the low bits of the modulus register are kept
  localparam int MW = (MOD_WIDTH < W) ? MOD_WIDTH : W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RED,   // reduce the incoming value modulo n
    S_EXP,   // one exponent bit per pass: multiply and square in parallel
    S_HOLD   // result ready, wait for the output register
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers. Write them only while idle; the block does not guard this.
  // Out-of-range indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [MW-1:0] modulus_q;
  logic [W-1:0]  pub_exp_q, priv_exp_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MW'(1);
      pub_exp_q  <= W'(1);
      priv_exp_q <= W'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rme_pkg::REG_MODULUS:  modulus_q  <= cfg_i.data[MW-1:0];
        rme_pkg::REG_PUB_EXP:  pub_exp_q  <= cfg_i.data;
        rme_pkg::REG_PRIV_EXP: priv_exp_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic [W-1:0] m_full;
  logic         m_zero;

  // Zero modulus means plain 32-bit wrap
  assign m_full = W'(modulus_q);
  assign m_zero = (modulus_q == '0);

  // ---------------------------------------------------------------------------
  // Datapath: acc holds the running product, sq the running power of the value.
  // The squarer unit also does the initial reduction of the value.
  // ---------------------------------------------------------------------------
  state_e            state_q;
  logic [W-1:0]      e_q, acc_q, sq_q, res_q;
  logic              out_valid_q, acc_start_q;
  rme_pkg::mm_ctrl_t sq_ctrl_q, acc_ctrl;
  logic              sq_done, acc_done;
  logic [W-1:0]      sq_r, acc_r, req_exp;

  assign acc_ctrl = '{start: acc_start_q, reduce: 1'b0};
  assign req_exp  = (req_i.func == rme_pkg::FUNC_DEC) ? priv_exp_q : pub_exp_q;

  rme_mulmod u_sq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (sq_ctrl_q),
    .a_i      (sq_q),
    .b_i      (sq_q),
    .m_i      (m_full),
    .m_zero_i (m_zero),
    .done_o   (sq_done),
    .r_o      (sq_r)
  );

  // acc is the serial operand: its unreduced start value of 1 is harmless there
  rme_mulmod u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (acc_ctrl),
    .a_i      (acc_q),
    .b_i      (sq_q),
    .m_i      (m_full),
    .m_zero_i (m_zero),
    .done_o   (acc_done),
    .r_o      (acc_r)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      e_q         <= '0;
      acc_q       <= '0;
      sq_q        <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      acc_start_q <= 1'b0;
      sq_ctrl_q   <= '0;
    end else begin
      sq_ctrl_q   <= '0;
      acc_start_q <= 1'b0;
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            sq_q  <= req_i.value;
            acc_q <= W'(1);
            e_q   <= req_exp;
            // zero exponent gives 1 with no reduction
            if (req_exp == '0) begin
              state_q <= S_HOLD;
            end else begin
              state_q   <= S_RED;
              sq_ctrl_q <= '{start: 1'b1, reduce: 1'b1};
            end
          end
        end
        S_RED: begin
          if (sq_done) begin
            sq_q        <= sq_r;
            sq_ctrl_q   <= '{start: 1'b1, reduce: 1'b0};
            acc_start_q <= e_q[0];
            state_q     <= S_EXP;
          end
        end
        S_EXP: begin
          // the multiplier, when started, starts and finishes together with the squarer
          if (sq_done) begin
            sq_q <= sq_r;
            if (e_q[0]) begin
              acc_q <= acc_r;
            end
            e_q <= {1'b0, e_q[W-1:1]};
            if (e_q[W-1:1] == '0) begin
              state_q <= S_HOLD;
            end else begin
              sq_ctrl_q   <= '{start: 1'b1, reduce: 1'b0};
              acc_start_q <= e_q[1];
            end
          end
        end
        S_HOLD: begin
          if (!out_valid_q || rsp_o.ready) begin
            res_q       <= acc_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.result = res_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`include "rsa_modexp_engine_macros.svh"

  `RME_ASSERT_NOW(a_acc_with_sq, acc_done, sq_done && state_q == S_EXP, "multiplier out of step with squarer")
  `RME_ASSERT_NOW(a_done_in_run, sq_done, state_q == S_RED || state_q == S_EXP, "squarer done outside a run")
  `RME_ASSERT_NEXT(a_sq_reduced, sq_done && !m_zero, sq_q < m_full, "power not reduced below modulus")
  `RME_ASSERT_NOW(a_hold_exp_spent, state_q == S_HOLD, e_q == '0, "result taken with exponent bits left")

endmodule
